FILE: hdl/rff_pkg.sv
package rff_pkg;

	localparam int HALF_POINTS = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int SAMPLE_W    = 16;
	localparam int BIN_W       = 6;
	localparam int ADDR_W      = $clog2(HALF_POINTS);
	localparam int LOG_HALF    = ADDR_W;
	localparam int STAGE_W     = (LOG_HALF > 2) ? $clog2(LOG_HALF) : 1;
	localparam int CNT_W       = ADDR_W + 1;
	localparam int TW_W        = 6;
	localparam int TW_SHIFT    = TW_W - LOG_HALF;
	localparam int DATA_W      = 32;
	localparam int OUT_TDATA_W = 72;
	localparam int PADDR_W     = 3;

	localparam logic REG_OFFSET = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	localparam logic [15:0] QSINE [33] = '{
		16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,  16'd9512,  16'd11039,
		16'd12540, 16'd14010, 16'd15447, 16'd16846, 16'd18205, 16'd19520, 16'd20788, 16'd22006,
		16'd23170, 16'd24279, 16'd25330, 16'd26320, 16'd27246, 16'd28106, 16'd28899, 16'd29622,
		16'd30274, 16'd30853, 16'd31357, 16'd31786, 16'd32138, 16'd32413, 16'd32610, 16'd32729,
		16'd32767
	};

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
	} tw_t;

	typedef enum logic [3:0] {
		DP_IDLE,
		DP_READ,
		DP_PREP,
		DP_MUL_RE,
		DP_MUL_IM,
		DP_SUM_IM,
		DP_WR_LO,
		DP_WR_HI,
		DP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_BF_RD,
		S_BF_MR,
		S_BF_MI,
		S_BF_GI,
		S_BF_W0,
		S_BF_W1,
		S_SP_RD,
		S_SP_PREP,
		S_SP_MR,
		S_SP_MI,
		S_SP_GI,
		S_SP_OUT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t            op;
		logic              load;
		logic [CNT_W-1:0]  load_cnt;
		logic [ADDR_W-1:0] rd_p;
		logic [ADDR_W-1:0] rd_q;
		logic [ADDR_W-1:0] wr_addr;
		logic              src_b;
		logic              first;
		logic              split;
		logic [TW_W-1:0]   twi;
		logic [ADDR_W-1:0] bin;
		logic              last;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// cos and -sin of pi*i/64
	function automatic tw_t twiddle(input logic [TW_W-1:0] i);
		tw_t w;
		logic [5:0] si;
		logic [5:0] ci;
		if (i <= 6'd32) begin
			si = i;
			ci = 6'd32 - i;
			w.re = $signed(QSINE[ci]);
		end else begin
			si = 6'(7'd64 - {1'b0, i});
			ci = i - 6'd32;
			w.re = -$signed(QSINE[ci]);
		end
		w.im = -$signed(QSINE[si]);
		return w;
	endfunction

	function automatic logic [ADDR_W-1:0] bitrev(input logic [ADDR_W-1:0] i);
		logic [ADDR_W-1:0] r;
		for (int n = 0; n < ADDR_W; n++) begin
			r[n] = i[ADDR_W-1-n];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] prod_round(input logic signed [48:0] x);
		logic signed [63:0] t;
		t = 64'(x) + 64'sd16384;
		return sat32(t >>> 15);
	endfunction

endpackage

FILE: hdl/real_input_fft_frame.sv
// Real-input FFT of a 2*HALF_POINTS sample frame (128 samples, 64 bins). Samples are taken one
// per cycle; after the last one the block runs a half-length radix-2 FFT on a single butterfly
// unit ((HALF_POINTS/2)*log2(HALF_POINTS) butterflies, each done as read, multiply real,
// multiply imaginary, sum, write low and write high) and a split pass over the bins, which waits
// on output back-pressure, and then takes samples again. The frame rate is set by the shared
// butterfly/multiplier unit and the single write port of each work memory. Bins
// 0..HALF_POINTS-1 come out in order, tlast on the final bin; the Nyquist bin is not given.
// Samples outside 0..signal_length-1 of the signal position (frame_offset plus index in frame)
// are zeroed.
module real_input_fft_frame (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [rff_pkg::SAMPLE_W-1:0]         s_tdata,  // [15:0] sample
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [rff_pkg::OUT_TDATA_W-1:0]      m_tdata,  // [5:0] bin_index, [37:6] bin_real, [69:38] bin_imag
	output logic                                 m_tlast,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rff_pkg::PADDR_W-1:0]          paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	logic signed [31:0] frame_offset_q;
	logic [30:0]        signal_length_q;

	rff_pkg::dp_cmd_t    cmd;
	rff_pkg::dp_status_t status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_offset_q  <= '0;
			signal_length_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				rff_pkg::REG_OFFSET: frame_offset_q  <= pwdata;
				rff_pkg::REG_LENGTH: signal_length_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rff_pkg::REG_OFFSET: prdata = frame_offset_q;
			rff_pkg::REG_LENGTH: prdata = {1'b0, signal_length_q};
			default: prdata = '0;
		endcase
	end

	rff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rff_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.sample        (s_tdata),
		.frame_offset  (frame_offset_q),
		.signal_length (signal_length_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast)
	);

endmodule

FILE: hdl/rff_ctrl.sv
module rff_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  rff_pkg::dp_status_t status,
	output rff_pkg::dp_cmd_t    cmd
);

	rff_pkg::ctrl_state_t state_q, state_nxt;

	logic [rff_pkg::CNT_W-1:0]   load_cnt_q;
	logic [rff_pkg::STAGE_W-1:0] stage_q;
	logic [rff_pkg::ADDR_W-1:0]  bf_q;
	logic [rff_pkg::ADDR_W-1:0]  bin_q;
	logic                        src_b_q;

	logic [rff_pkg::ADDR_W-1:0] mask, jm, g, g2;
	logic [rff_pkg::TW_W-1:0]   bf_twi;
	logic bf_end, stage_end, frame_end, bin_end;

	assign frame_end = (load_cnt_q == rff_pkg::CNT_W'(2 * rff_pkg::HALF_POINTS - 1));
	assign bf_end    = (bf_q == rff_pkg::ADDR_W'(rff_pkg::HALF_POINTS / 2 - 1));
	assign stage_end = (stage_q == rff_pkg::STAGE_W'(rff_pkg::LOG_HALF - 1));
	assign bin_end   = (bin_q == rff_pkg::ADDR_W'(rff_pkg::HALF_POINTS - 1));

	// butterfly pair of the current stage
	always_comb begin
		mask   = (rff_pkg::ADDR_W'(1) << stage_q) - rff_pkg::ADDR_W'(1);
		jm     = bf_q & mask;
		g      = ((bf_q >> stage_q) << ({1'b0, stage_q} + 1'b1)) | jm;
		g2     = g | (rff_pkg::ADDR_W'(1) << stage_q);
		bf_twi = rff_pkg::TW_W'(jm) << (rff_pkg::TW_W - 32'(stage_q));
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rff_pkg::S_LOAD: begin
				if (s_tvalid && frame_end) state_nxt = rff_pkg::S_BF_RD;
			end
			rff_pkg::S_BF_RD: state_nxt = rff_pkg::S_BF_MR;
			rff_pkg::S_BF_MR: state_nxt = rff_pkg::S_BF_MI;
			rff_pkg::S_BF_MI: state_nxt = rff_pkg::S_BF_GI;
			rff_pkg::S_BF_GI: state_nxt = rff_pkg::S_BF_W0;
			rff_pkg::S_BF_W0: state_nxt = rff_pkg::S_BF_W1;
			rff_pkg::S_BF_W1: begin
				if (bf_end && stage_end) state_nxt = rff_pkg::S_SP_RD;
				else state_nxt = rff_pkg::S_BF_RD;
			end
			rff_pkg::S_SP_RD:   state_nxt = rff_pkg::S_SP_PREP;
			rff_pkg::S_SP_PREP: state_nxt = rff_pkg::S_SP_MR;
			rff_pkg::S_SP_MR:   state_nxt = rff_pkg::S_SP_MI;
			rff_pkg::S_SP_MI:   state_nxt = rff_pkg::S_SP_GI;
			rff_pkg::S_SP_GI:   state_nxt = rff_pkg::S_SP_OUT;
			rff_pkg::S_SP_OUT: begin
				if (status.out_free) begin
					state_nxt = bin_end ? rff_pkg::S_LOAD : rff_pkg::S_SP_RD;
				end
			end
			default: state_nxt = rff_pkg::S_LOAD;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.op       = rff_pkg::DP_IDLE;
		cmd.load_cnt = load_cnt_q;
		cmd.src_b    = src_b_q;
		cmd.first    = (stage_q == '0);
		cmd.bin      = bin_q;
		cmd.last     = bin_end;
		s_tready     = 1'b0;
		cmd.split    = 1'b0;
		cmd.twi      = bf_twi;
		cmd.rd_p     = (stage_q == '0) ? rff_pkg::bitrev(g) : g;
		cmd.rd_q     = (stage_q == '0) ? rff_pkg::bitrev(g2) : g2;
		cmd.wr_addr  = g;
		unique case (state_q)
			rff_pkg::S_LOAD: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			rff_pkg::S_BF_RD: cmd.op = rff_pkg::DP_READ;
			rff_pkg::S_BF_MR: cmd.op = rff_pkg::DP_MUL_RE;
			rff_pkg::S_BF_MI: cmd.op = rff_pkg::DP_MUL_IM;
			rff_pkg::S_BF_GI: cmd.op = rff_pkg::DP_SUM_IM;
			rff_pkg::S_BF_W0: cmd.op = rff_pkg::DP_WR_LO;
			rff_pkg::S_BF_W1: begin
				cmd.op      = rff_pkg::DP_WR_HI;
				cmd.wr_addr = g2;
			end
			rff_pkg::S_SP_RD, rff_pkg::S_SP_PREP, rff_pkg::S_SP_MR, rff_pkg::S_SP_MI,
			rff_pkg::S_SP_GI, rff_pkg::S_SP_OUT: begin
				cmd.split = 1'b1;
				cmd.first = 1'b0;
				cmd.twi   = rff_pkg::TW_W'(bin_q) << rff_pkg::TW_SHIFT;
				cmd.rd_p  = bin_q;
				cmd.rd_q  = rff_pkg::ADDR_W'(0) - bin_q;
				unique case (state_q)
					rff_pkg::S_SP_RD:   cmd.op = rff_pkg::DP_READ;
					rff_pkg::S_SP_PREP: cmd.op = rff_pkg::DP_PREP;
					rff_pkg::S_SP_MR:   cmd.op = rff_pkg::DP_MUL_RE;
					rff_pkg::S_SP_MI:   cmd.op = rff_pkg::DP_MUL_IM;
					rff_pkg::S_SP_GI:   cmd.op = rff_pkg::DP_SUM_IM;
					rff_pkg::S_SP_OUT: begin
						cmd.op = status.out_free ? rff_pkg::DP_OUT : rff_pkg::DP_IDLE;
					end
					default: cmd.op = rff_pkg::DP_IDLE;
				endcase
			end
			default: cmd.op = rff_pkg::DP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rff_pkg::S_LOAD;
			load_cnt_q <= '0;
			stage_q    <= '0;
			bf_q       <= '0;
			bin_q      <= '0;
			src_b_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == rff_pkg::S_LOAD && s_tvalid) begin
				load_cnt_q <= frame_end ? '0 : load_cnt_q + 1'b1;
				stage_q    <= '0;
				bf_q       <= '0;
				src_b_q    <= 1'b0;
			end
			if (state_q == rff_pkg::S_BF_W1) begin
				if (bf_end) begin
					bf_q    <= '0;
					src_b_q <= ~src_b_q;
					bin_q   <= '0;
					if (!stage_end) stage_q <= stage_q + 1'b1;
				end else begin
					bf_q <= bf_q + 1'b1;
				end
			end
			if (state_q == rff_pkg::S_SP_OUT && status.out_free) begin
				bin_q <= bin_q + 1'b1;
			end
		end
	end

endmodule

FILE: hdl/rff_dp.sv
module rff_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rff_pkg::dp_cmd_t                  cmd,
	output rff_pkg::dp_status_t               status,
	input  logic [rff_pkg::SAMPLE_W-1:0]      sample,
	input  logic signed [31:0]                frame_offset,
	input  logic [30:0]                       signal_length,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rff_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);

	localparam int N = rff_pkg::HALF_POINTS;
	localparam int AW = rff_pkg::ADDR_W;

	logic signed [31:0] ra [N];
	logic signed [31:0] ia [N];
	logic signed [31:0] rb [N];
	logic signed [31:0] ib [N];

	logic signed [31:0] rap_q, raq_q, iap_q, iaq_q, rbp_q, rbq_q, ibp_q, ibq_q;
	logic signed [31:0] xr, xi, yr, yi, opr, opi;
	rff_pkg::tw_t       tw_q;
	logic signed [31:0] ar_q, ai_q, gr_q, gi_q;
	logic signed [32:0] sre_q, sim_q;
	logic signed [47:0] p1_q, p2_q;

	logic signed [32:0] pos;
	logic               in_range;
	logic signed [31:0] ld_val;
	logic [AW-1:0]      ld_addr;

	logic               a_re_we, a_im_we, b_re_we, b_im_we;
	logic [AW-1:0]      a_addr, b_addr;
	logic signed [31:0] a_re_d, a_im_d, wr_re, wr_im;

	logic [rff_pkg::BIN_W-1:0] idx_q;
	logic signed [31:0]        re_q, im_q;
	logic                      last_q;

	assign status.out_free = !m_tvalid || m_tready;

	// sample gating by signal position
	always_comb begin
		pos      = 33'(frame_offset) + $signed({1'b0, 32'(cmd.load_cnt)});
		in_range = !pos[32] && (pos[31:0] < {1'b0, signal_length});
		ld_val   = in_range ? 32'($signed(sample[rff_pkg::SAMPLE_BITS-1:0])) : 32'sd0;
		ld_addr  = cmd.load_cnt[AW:1];
	end

	always_comb begin
		xr  = cmd.src_b ? rbp_q : rap_q;
		xi  = cmd.src_b ? ibp_q : iap_q;
		yr  = cmd.src_b ? rbq_q : raq_q;
		yi  = cmd.src_b ? ibq_q : iaq_q;
		opr = cmd.split ? ar_q : yr;
		opi = cmd.split ? ai_q : yi;
	end

	always_comb begin
		wr_re = '0;
		wr_im = '0;
		if (cmd.op == rff_pkg::DP_WR_HI) begin
			wr_re = rff_pkg::sat32(64'(xr) - 64'(gr_q));
			wr_im = rff_pkg::sat32(64'(xi) - 64'(gi_q));
		end else begin
			wr_re = rff_pkg::sat32(64'(xr) + 64'(gr_q));
			wr_im = rff_pkg::sat32(64'(xi) + 64'(gi_q));
		end
	end

	always_comb begin
		logic bf_we;
		bf_we   = (cmd.op == rff_pkg::DP_WR_LO) || (cmd.op == rff_pkg::DP_WR_HI);
		a_re_we = (cmd.load && !cmd.load_cnt[0]) || (bf_we && cmd.src_b);
		a_im_we = (cmd.load && cmd.load_cnt[0]) || (bf_we && cmd.src_b);
		b_re_we = bf_we && !cmd.src_b;
		b_im_we = bf_we && !cmd.src_b;
		a_addr  = cmd.load ? ld_addr : cmd.wr_addr;
		b_addr  = cmd.wr_addr;
		a_re_d  = cmd.load ? ld_val : wr_re;
		a_im_d  = cmd.load ? ld_val : wr_im;
	end

	always_ff @(posedge clk) begin
		if (a_re_we) ra[a_addr] <= a_re_d;
		if (a_im_we) ia[a_addr] <= a_im_d;
		if (b_re_we) rb[b_addr] <= wr_re;
		if (b_im_we) ib[b_addr] <= wr_im;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == rff_pkg::DP_READ) begin
			rap_q <= ra[cmd.rd_p];
			raq_q <= ra[cmd.rd_q];
			iap_q <= ia[cmd.rd_p];
			iaq_q <= ia[cmd.rd_q];
			rbp_q <= rb[cmd.rd_p];
			rbq_q <= rb[cmd.rd_q];
			ibp_q <= ib[cmd.rd_p];
			ibq_q <= ib[cmd.rd_q];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			rff_pkg::DP_READ: tw_q <= rff_pkg::twiddle(cmd.twi);
			rff_pkg::DP_PREP: begin
				ar_q  <= rff_pkg::sat32(64'(xi) + 64'(yi));
				ai_q  <= rff_pkg::sat32(64'(yr) - 64'(xr));
				sre_q <= 33'(xr) + 33'(yr);
				sim_q <= 33'(xi) - 33'(yi);
			end
			rff_pkg::DP_MUL_RE: begin
				p1_q <= 48'(opr) * 48'(tw_q.re);
				p2_q <= 48'(opi) * 48'(tw_q.im);
			end
			rff_pkg::DP_MUL_IM: begin
				p1_q <= 48'(opr) * 48'(tw_q.im);
				p2_q <= 48'(opi) * 48'(tw_q.re);
				gr_q <= cmd.first ? yr : rff_pkg::prod_round(49'(p1_q) - 49'(p2_q));
			end
			rff_pkg::DP_SUM_IM: begin
				gi_q <= cmd.first ? yi : rff_pkg::prod_round(49'(p1_q) + 49'(p2_q));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.op == rff_pkg::DP_OUT) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == rff_pkg::DP_OUT) begin
			idx_q  <= rff_pkg::BIN_W'(cmd.bin);
			last_q <= cmd.last;
			if (cmd.bin == '0) begin
				re_q <= rff_pkg::sat32(64'(xr) + 64'(xi));
				im_q <= '0;
			end else begin
				re_q <= rff_pkg::sat32((64'(sre_q) + 64'(gr_q)) >>> 1);
				im_q <= rff_pkg::sat32((64'(sim_q) + 64'(gi_q)) >>> 1);
			end
		end
	end

	assign m_tdata = {2'b00, im_q, re_q, idx_q};
	assign m_tlast = last_q;

endmodule

FILE: tb/real_input_fft_frame_chk.sv
`timescale 1ns / 100ps

module real_input_fft_frame_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rff_pkg::SAMPLE_W-1:0]    s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rff_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            m_tlast,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rff_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	input  logic                            pready,
	output int                              fail_count,
	output int                              bins_pending
);

	localparam int NPTS = rff_pkg::HALF_POINTS;

	typedef struct {
		logic [5:0]  idx;
		logic [31:0] re;
		logic [31:0] im;
		logic        last;
	} bin_t;

	bin_t bin_q[$];

	longint      offset_r;
	longint      length_r;
	int          fill;
	int          ar[2][64];
	int          ai[2][64];

	assign bins_pending = bin_q.size();

	function automatic int clip(input longint x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return int'(x);
	endfunction

	function automatic int rev6(input int i);
		int r;
		int v;
		r = 0;
		v = i;
		for (int n = NPTS; n > 1; n >>= 1) begin
			r = (r << 1) | (v & 1);
			v >>= 1;
		end
		return r & 63;
	endfunction

	function automatic void rot(input int k, output longint wr, output longint wi);
		int i;
		i = (k * (64 / NPTS)) & 63;
		if (i <= 32) begin
			wr = longint'(rff_pkg::QSINE[32 - i]);
			wi = -longint'(rff_pkg::QSINE[i]);
		end else begin
			wr = -longint'(rff_pkg::QSINE[i - 32]);
			wi = -longint'(rff_pkg::QSINE[64 - i]);
		end
	endfunction

	function automatic void cmul(input longint a, input longint b, input longint wr,
			input longint wi, output int cr, output int ci);
		cr = clip((a * wr - b * wi + 16384) >>> 15);
		ci = clip((a * wi + b * wr + 16384) >>> 15);
	endfunction

	task automatic transform_frame();
		int s;
		int d;
		int p;
		int q;
		int g2;
		int nk;
		int gr;
		int gi;
		int xr;
		int xi;
		longint wr;
		longint wi;
		bin_t b;
		for (int i = 0; i + 1 < NPTS; i += 2) begin
			p = rev6(i);
			q = rev6(i + 1);
			ar[1][i]     = clip(longint'(ar[0][p]) + ar[0][q]);
			ai[1][i]     = clip(longint'(ai[0][p]) + ai[0][q]);
			ar[1][i + 1] = clip(longint'(ar[0][p]) - ar[0][q]);
			ai[1][i + 1] = clip(longint'(ai[0][p]) - ai[0][q]);
		end
		s = 1;
		for (int m = 2; m < NPTS; m <<= 1) begin
			d = 1 - s;
			for (int j = 0; j < m; j++) begin
				rot(j * (NPTS / m), wr, wi);
				for (int g = j; g < NPTS; g += 2 * m) begin
					g2 = (g + m) & 63;
					cmul(ar[s][g2], ai[s][g2], wr, wi, gr, gi);
					ar[d][g]  = clip(longint'(ar[s][g]) + gr);
					ai[d][g]  = clip(longint'(ai[s][g]) + gi);
					ar[d][g2] = clip(longint'(ar[s][g]) - gr);
					ai[d][g2] = clip(longint'(ai[s][g]) - gi);
				end
			end
			s = d;
		end
		b.idx  = 0;
		b.re   = clip(longint'(ar[s][0]) + ai[s][0]);
		b.im   = 0;
		b.last = (NPTS == 1);
		bin_q.push_back(b);
		for (int k = 1; k < NPTS; k++) begin
			nk = (NPTS - k) & 63;
			xr = clip(longint'(ai[s][k]) + ai[s][nk]);
			xi = clip(longint'(ar[s][nk]) - ar[s][k]);
			rot(k, wr, wi);
			cmul(xr, xi, wr, wi, gr, gi);
			b.idx  = k[5:0];
			b.re   = clip((longint'(ar[s][k]) + ar[s][nk] + gr) >>> 1);
			b.im   = clip((longint'(ai[s][k]) - ai[s][nk] + gi) >>> 1);
			b.last = (k == NPTS - 1);
			bin_q.push_back(b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint pos;
		int v;
		bin_t e;
		if (!arst_n) begin
			offset_r   = 0;
			length_r   = 0;
			fill       = 0;
			fail_count = 0;
			bin_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {rff_pkg::REG_OFFSET, 2'b00}) begin
					offset_r = longint'($signed(pwdata));
				end else if (paddr == {rff_pkg::REG_LENGTH, 2'b00}) begin
					length_r = longint'(pwdata[30:0]);
				end
			end
			if (s_tvalid && s_tready) begin
				pos = offset_r + fill;
				v   = int'($signed(s_tdata));
				if (pos < 0 || pos >= length_r) begin
					v = 0;
				end
				if (fill & 1) begin
					ai[0][(fill >> 1) & 63] = v;
				end else begin
					ar[0][(fill >> 1) & 63] = v;
				end
				fill++;
				if (fill == 2 * NPTS) begin
					fill = 0;
					transform_frame();
				end
			end
			if (m_tvalid && m_tready) begin
				if (bin_q.size() == 0) begin
					$error("unexpected bin %0d", m_tdata[5:0]);
					fail_count++;
				end else begin
					e = bin_q.pop_front();
					if (m_tdata[5:0] !== e.idx) begin
						$error("bin_index exp %0d got %0d", e.idx, m_tdata[5:0]);
						fail_count++;
					end
					if (m_tdata[37:6] !== e.re) begin
						$error("bin_real exp %0d got %0d", $signed(e.re),
							$signed(m_tdata[37:6]));
						fail_count++;
					end
					if (m_tdata[69:38] !== e.im) begin
						$error("bin_imag exp %0d got %0d", $signed(e.im),
							$signed(m_tdata[69:38]));
						fail_count++;
					end
					if (m_tlast !== e.last) begin
						$error("last_bin exp %0d got %0d", e.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

FILE: tb/real_input_fft_frame_tb.sv
`timescale 1ns / 100ps

module real_input_fft_frame_tb;

	localparam int CYCLE_LIMIT = 400000;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [rff_pkg::SAMPLE_W-1:0]      s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [rff_pkg::OUT_TDATA_W-1:0]   m_tdata;
	logic                              m_tlast;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [rff_pkg::PADDR_W-1:0]       paddr;
	logic [31:0]                       pwdata;
	logic [31:0]                       prdata;
	logic                              pready;
	int                                fail_count;
	int                                bins_pending;
	int                                cycles;
	int                                stall_left;

	real_input_fft_frame u_dut (.*);

	real_input_fft_frame_chk u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// output back-pressure: mostly ready, short stalls, now and then a long one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			case ($urandom_range(0, 19))
				0, 1, 2: stall_left = $urandom_range(1, 3);
				3:       stall_left = $urandom_range(10, 40);
				default: stall_left = 0;
			endcase
		end
	end

	task automatic reg_write(input logic idx, input logic [31:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [15:0] v, input bit burst);
		int gap;
		gap = 0;
		if (!burst) begin
			case ($urandom_range(0, 9))
				0, 1:    gap = $urandom_range(1, 3);
				2:       gap = $urandom_range(8, 30);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic run_frame(input bit directed, input bit burst);
		logic [15:0] corner [20];
		logic [15:0] v;
		corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'haaaa,
			16'h5555, 16'hcccc, 16'h3333, 16'hf0f0, 16'h0f0f, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h4000};
		for (int i = 0; i < 2 * rff_pkg::HALF_POINTS; i++) begin
			if (directed && i < 20) begin
				v = corner[i];
			end else if ($urandom_range(0, 3) == 0) begin
				v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			end else if ($urandom_range(0, 2) == 0) begin
				v = 16'($signed($urandom_range(0, 511)) - 256);
			end else begin
				v = $urandom();
			end
			send_sample(v, burst);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bins_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(rff_pkg::REG_LENGTH, 32'hffffffff);
		run_frame(1'b1, 1'b1);

		reg_write(rff_pkg::REG_OFFSET, 32'hfffffff8);
		reg_write(rff_pkg::REG_LENGTH, 32'd60);
		run_frame(1'b1, 1'b0);

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
